[rtl/stcc_pkg.sv]
// Shared constants and types for the scale tare and calibrate controller.
`default_nettype none

package stcc_pkg;

	localparam int SAMPLE_BITS_DEF       = 24;
	localparam int COUNTS_PER_DETENT_DEF = 2;
	localparam int DIV_BITS              = 32;
	localparam int START_BITS            = 31;
	localparam int COUNT_BITS            = 16;
	localparam int RECIP_SHIFT           = 17;

	localparam logic [DIV_BITS-1:0] DEFAULT_DIVISOR = 32'd1724;
	localparam logic [DIV_BITS-1:0] DIVISOR_MAX     = 32'h7FFF_FFFF;
	localparam logic [DIV_BITS-1:0] DIVISOR_MIN     = 32'h8000_0000;
	localparam logic [DIV_BITS-1:0] DIVISOR_ONE     = 32'd1;

	typedef enum logic [1:0] {
		NOTICE_NONE      = 2'd0,
		NOTICE_TARED     = 2'd1,
		NOTICE_SAVED     = 2'd2,
		NOTICE_CANCELLED = 2'd3
	} notice_t;

	typedef enum logic {
		MODE_WEIGH  = 1'b0,
		MODE_ADJUST = 1'b1
	} mode_code_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

[rtl/scale_tare_calibrate_controller_top.sv]
// Top level of the scale tare and calibrate controller with its serial divider.
//
// Use: each request on the s_ channel is one control-loop tick: s_tuser flags a
// new load-cell sample, s_tdata carries the sample, the three button levels and
// the encoder count. Each tick yields exactly one result on the m_ channel with
// weight, net, held sample, mode, divisor, save pulse and notice.
// The cfg channel loads start_divisor into the divisor; it is taken only between
// ticks and wins over a tick offered in the same cycle.
// Steps: a tick with a sample passes one prepare step, the shared restoring
// divider (one quotient bit per cycle) and one finish step.
// A tick without a sample skips the divider and goes straight to the finish step.
// Throughput: one tick in flight at a time; s_tready returns together with the
// registered result, and no new tick is taken before then.
// A finished result waits in the output register while the next tick is accepted;
// a stalled m_tready holds it and then holds the finish step until it frees.
// Reset: divisor and its backup return to 1724, scale mode, all else zero,
// no result pending.
`default_nettype none

module scale_tare_calibrate_controller_top
	import stcc_pkg::*;
#(
	parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
	parameter int COUNTS_PER_DETENT = COUNTS_PER_DETENT_DEF
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        cfg_valid,
	output logic                                       cfg_ready,
	input  wire  [START_BITS-1:0]                      cfg_data,
	input  wire                                        s_tvalid,
	output logic                                       s_tready,
	// sample, confirm_down, back_down, push_down, encoder_count, zero fill
	input  wire  [((SAMPLE_BITS+COUNT_BITS+3+7)/8)*8-1:0] s_tdata,
	// sample_valid
	input  wire                                        s_tuser,
	output logic                                       m_tvalid,
	input  wire                                        m_tready,
	// weight_tenths, net_code, held_sample, tared, mode, divisor, save_now,
	// save_value, notice, zero fill
	output logic [((3*SAMPLE_BITS+75+7)/8)*8-1:0]      m_tdata
);

	localparam int SB      = SAMPLE_BITS;
	localparam int NB      = SB + 1;
	localparam int PB      = SB + 5;
	localparam int OUT_RAW = 3 * SB + 75;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int CNT_W   = $clog2(PB + 1);
	localparam int RECIP   = ((1 << RECIP_SHIFT) + COUNTS_PER_DETENT - 1) / COUNTS_PER_DETENT;
	localparam int RECIP_W = RECIP_SHIFT + 1;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PB - 1);

	// input fields
	logic signed [SB-1:0]         in_sample;
	logic [2:0]                   in_down;
	logic [COUNT_BITS-1:0]        in_count;

	// architectural state
	logic signed [SB-1:0]         last_sample_q;
	logic signed [SB-1:0]         tare_q;
	logic signed [NB-1:0]         net_q;
	logic signed [PB-1:0]         weight_q;
	logic [DIV_BITS-1:0]          divisor_q;
	logic [DIV_BITS-1:0]          backup_q;
	logic                         mode_q;
	logic                         tared_q;
	logic [2:0]                   btn_prev_q;
	logic [COUNT_BITS-1:0]        prev_count_q;

	// per-tick pending results
	logic                         valid_q;
	logic                         save_q;
	logic [DIV_BITS-1:0]          save_val_q;
	notice_t                      notice_q;

	// divider
	state_t                       state_q;
	logic [DIV_BITS-1:0]          dmag_q;
	logic                         dzero_q;
	logic                         dneg_q;
	logic                         qneg_q;
	logic [PB-1:0]                num_q;
	logic [DIV_BITS-1:0]          rem_q;
	logic [CNT_W-1:0]             cnt_q;

	logic                         out_valid_q;
	logic [OUT_W-1:0]             out_data_q;

	// combinational
	logic                         accept;
	logic [2:0]                   pressed;
	logic signed [SB-1:0]         sample_now;
	logic [COUNT_BITS-1:0]        diff;
	logic [COUNT_BITS-1:0]        diff_mag;
	logic [COUNT_BITS+RECIP_W-1:0] det_prod;
	logic [COUNT_BITS:0]          det_mag;
	logic signed [COUNT_BITS:0]   delta;
	logic signed [DIV_BITS+1:0]   adj_sum;
	logic [DIV_BITS-1:0]          adj_div;
	logic [DIV_BITS-1:0]          div_nxt;
	logic [DIV_BITS-1:0]          backup_nxt;
	logic                         mode_nxt;
	logic                         tare_hit;
	logic                         save_nxt;
	logic [DIV_BITS-1:0]          save_val_nxt;
	notice_t                      notice_nxt;
	logic signed [PB-1:0]         net_ext;
	logic signed [PB-1:0]         prod;
	logic [PB-1:0]                prod_mag;
	logic [DIV_BITS:0]            trial;
	logic                         trial_ge;
	logic [DIV_BITS:0]            trial_sub;
	logic signed [PB-1:0]         weight_nxt;
	logic                         out_free;

	assign in_sample = s_tdata[SB-1:0];
	assign in_down   = s_tdata[SB+2:SB];
	assign in_count  = s_tdata[SB+COUNT_BITS+2:SB+3];

	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// tick control
	always_comb begin
		pressed    = in_down & ~btn_prev_q;
		sample_now = s_tuser ? in_sample : last_sample_q;

		diff     = in_count - prev_count_q;
		diff_mag = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
		det_prod = {{RECIP_W{1'b0}}, diff_mag} * (COUNT_BITS+RECIP_W)'(RECIP);
		det_mag  = (COUNT_BITS+1)'(det_prod >> RECIP_SHIFT);
		delta    = diff[COUNT_BITS-1] ? -$signed(det_mag) : $signed(det_mag);

		adj_sum = $signed({{2{divisor_q[DIV_BITS-1]}}, divisor_q})
			+ (DIV_BITS+2)'(delta);
		if (adj_sum > $signed({2'b00, DIVISOR_MAX})) begin
			adj_div = DIVISOR_MAX;
		end else if (adj_sum < $signed({2'b11, DIVISOR_MIN})) begin
			adj_div = DIVISOR_MIN;
		end else if (adj_sum == '0) begin
			adj_div = DIVISOR_ONE;
		end else begin
			adj_div = adj_sum[DIV_BITS-1:0];
		end

		div_nxt      = divisor_q;
		backup_nxt   = backup_q;
		mode_nxt     = mode_q;
		tare_hit     = 1'b0;
		save_nxt     = 1'b0;
		save_val_nxt = '0;
		notice_nxt   = NOTICE_NONE;
		if (mode_q == MODE_WEIGH) begin
			if (pressed[0]) begin
				tare_hit   = 1'b1;
				notice_nxt = NOTICE_TARED;
			end
			if (pressed[2]) begin
				backup_nxt = divisor_q;
				mode_nxt   = MODE_ADJUST;
			end
		end else begin
			if (delta != '0) begin
				div_nxt = adj_div;
			end
			if (pressed[0]) begin
				save_nxt     = 1'b1;
				save_val_nxt = div_nxt;
				mode_nxt     = MODE_WEIGH;
				notice_nxt   = NOTICE_SAVED;
			end
			if (pressed[1]) begin
				div_nxt    = backup_q;
				mode_nxt   = MODE_WEIGH;
				notice_nxt = NOTICE_CANCELLED;
			end
		end
	end

	// divider datapath
	always_comb begin
		net_ext  = PB'(net_q);
		prod     = (net_ext <<< 3) + (net_ext <<< 1);
		prod_mag = prod[PB-1] ? (~prod + 1'b1) : prod;

		trial     = {rem_q, num_q[PB-1]};
		trial_ge  = trial >= {1'b0, dmag_q};
		trial_sub = trial - {1'b0, dmag_q};

		if (dzero_q) begin
			weight_nxt = '0;
		end else if (qneg_q) begin
			weight_nxt = -$signed(num_q);
		end else begin
			weight_nxt = $signed(num_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_sample_q <= '0;
			tare_q        <= '0;
			net_q         <= '0;
			weight_q      <= '0;
			divisor_q     <= DEFAULT_DIVISOR;
			backup_q      <= DEFAULT_DIVISOR;
			mode_q        <= MODE_WEIGH;
			tared_q       <= 1'b0;
			btn_prev_q    <= '0;
			prev_count_q  <= '0;
			valid_q       <= 1'b0;
			save_q        <= 1'b0;
			save_val_q    <= '0;
			notice_q      <= NOTICE_NONE;
			dmag_q        <= '0;
			dzero_q       <= 1'b0;
			dneg_q        <= 1'b0;
			qneg_q        <= 1'b0;
			num_q         <= '0;
			rem_q         <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						divisor_q <= {1'b0, cfg_data};
					end else if (accept) begin
						valid_q    <= s_tuser;
						btn_prev_q <= in_down;
						prev_count_q <= in_count;
						divisor_q  <= div_nxt;
						backup_q   <= backup_nxt;
						mode_q     <= mode_nxt;
						save_q     <= save_nxt;
						save_val_q <= save_val_nxt;
						notice_q   <= notice_nxt;
						dmag_q     <= divisor_q[DIV_BITS-1] ? (~divisor_q + 1'b1) : divisor_q;
						dneg_q     <= divisor_q[DIV_BITS-1];
						dzero_q    <= (divisor_q == '0);
						if (s_tuser) begin
							last_sample_q <= in_sample;
							net_q <= NB'(in_sample) - NB'(tare_q);
						end
						if (tare_hit) begin
							tare_q  <= sample_now;
							tared_q <= 1'b1;
						end
						state_q <= s_tuser ? ST_PREP : ST_DONE;
					end
				end
				ST_PREP: begin
					num_q   <= prod_mag;
					qneg_q  <= prod[PB-1] ^ dneg_q;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (trial_ge) begin
						rem_q <= trial_sub[DIV_BITS-1:0];
					end else begin
						rem_q <= trial[DIV_BITS-1:0];
					end
					num_q <= {num_q[PB-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= OUT_W'({notice_q, save_val_q, save_q, divisor_q,
							mode_q, tared_q, last_sample_q, net_q,
							(valid_q ? weight_nxt : weight_q)});
						if (valid_q) begin
							weight_q <= weight_nxt;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[verif/tb_scale_tare_calibrate_controller_top.sv]
// Testbench for scale_tare_calibrate_controller_top: directed and random ticks vs. a predictor.
`timescale 1ns / 100ps

module tb_scale_tare_calibrate_controller_top
	import stcc_pkg::*;
();

	localparam int TICK_W         = ((SAMPLE_BITS_DEF + COUNT_BITS + 3 + 7) / 8) * 8;
	localparam int READOUT_W      = ((3 * SAMPLE_BITS_DEF + 75 + 7) / 8) * 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	typedef struct {
		logic              sample_valid;
		logic signed [23:0] sample;
		logic              confirm;
		logic              back;
		logic              push;
		logic [15:0]       count;
	} tick_t;

	typedef struct {
		logic signed [28:0] weight;
		logic signed [24:0] net;
		logic signed [23:0] held;
		logic               tared;
		logic               mode;
		logic signed [31:0] divisor;
		logic               save_now;
		logic signed [31:0] save_value;
		notice_t            notice;
	} readout_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [START_BITS-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TICK_W-1:0]      s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [READOUT_W-1:0]   m_tdata;

	// scale state as the block should hold it
	logic signed [23:0] held_smp   = '0;
	logic signed [23:0] tare_smp   = '0;
	longint             net_val    = 0;
	longint             weight_val = 0;
	longint             div_val    = longint'(DEFAULT_DIVISOR);
	longint             div_backup = longint'(DEFAULT_DIVISOR);
	mode_code_t         cal_mode   = MODE_WEIGH;
	logic               is_tared   = 1'b0;
	logic [2:0]         btn_prev   = '0;
	logic [15:0]        enc_prev   = '0;

	readout_t pending_readouts[$];
	int       mismatches   = 0;
	int       quiet_cycles = 0;

	rx_style_t   rx_style    = RX_RANDOM;
	bit          sender_gaps = 1'b1;
	bit          hold_req    = 1'b0;
	int          burst_left  = 0;
	logic [2:0]  btn_lvl     = '0;
	logic [15:0] enc_lvl     = '0;

	scale_tare_calibrate_controller_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic readout_t next_scale_readout(input tick_t t);
		readout_t    r;
		logic [2:0]  down;
		logic [2:0]  rise;
		logic [15:0] diff;
		longint      old_div;
		longint      delta;
		longint      adj;
		old_div = div_val;
		down = {t.push, t.back, t.confirm};
		if (t.sample_valid) begin
			held_smp = t.sample;
			net_val = longint'(t.sample) - longint'(tare_smp);
			weight_val = (old_div == 0) ? 0 : (net_val * 10) / old_div;
		end
		rise = down & ~btn_prev;
		btn_prev = down;
		diff = t.count - enc_prev;
		delta = longint'($signed(diff)) / COUNTS_PER_DETENT_DEF;
		enc_prev = t.count;
		r.save_now = 1'b0;
		r.save_value = '0;
		r.notice = NOTICE_NONE;
		if (cal_mode == MODE_WEIGH) begin
			if (rise[0]) begin
				tare_smp = held_smp;
				is_tared = 1'b1;
				r.notice = NOTICE_TARED;
			end
			if (rise[2]) begin
				div_backup = div_val;
				cal_mode = MODE_ADJUST;
			end
		end else begin
			if (delta != 0) begin
				adj = div_val + delta;
				if (adj > longint'($signed(DIVISOR_MAX)))
					adj = longint'($signed(DIVISOR_MAX));
				if (adj < longint'($signed(DIVISOR_MIN)))
					adj = longint'($signed(DIVISOR_MIN));
				if (adj == 0)
					adj = longint'(DIVISOR_ONE);
				div_val = adj;
			end
			if (rise[0]) begin
				r.save_now = 1'b1;
				r.save_value = 32'(div_val);
				cal_mode = MODE_WEIGH;
				r.notice = NOTICE_SAVED;
			end
			if (rise[1]) begin
				div_val = div_backup;
				cal_mode = MODE_WEIGH;
				r.notice = NOTICE_CANCELLED;
			end
		end
		r.weight = 29'(weight_val);
		r.net = 25'(net_val);
		r.held = held_smp;
		r.tared = is_tared;
		r.mode = (cal_mode == MODE_ADJUST);
		r.divisor = 32'(div_val);
		return r;
	endfunction

	function automatic readout_t unpack_readout(input logic [READOUT_W-1:0] d);
		readout_t r;
		r.weight = d[28:0];
		r.net = d[53:29];
		r.held = d[77:54];
		r.tared = d[78];
		r.mode = d[79];
		r.divisor = d[111:80];
		r.save_now = d[112];
		r.save_value = d[144:113];
		r.notice = notice_t'(d[146:145]);
		return r;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic tick_t tick_of(input logic vld, input logic signed [23:0] smp,
			input logic c, input logic b, input logic p, input logic [15:0] cnt);
		tick_t t;
		t.sample_valid = vld;
		t.sample = smp;
		t.confirm = c;
		t.back = b;
		t.push = p;
		t.count = cnt;
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		t.sample_valid = ($urandom_range(0, 9) < 7);
		case ($urandom_range(0, 15))
			0: t.sample = 24'sh7FFFFF;
			1: t.sample = 24'sh800000;
			2: t.sample = '0;
			default: t.sample = 24'($urandom());
		endcase
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) == 0)
				btn_lvl[i] = ~btn_lvl[i];
		end
		if ($urandom_range(0, 15) == 0)
			enc_lvl = 16'($urandom());
		else
			enc_lvl = 16'(enc_lvl + $urandom_range(0, 12) - 6);
		t.confirm = btn_lvl[0];
		t.back = btn_lvl[1];
		t.push = btn_lvl[2];
		t.count = enc_lvl;
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		if (sender_gaps && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tuser <= t.sample_valid;
		s_tdata <= TICK_W'({t.count, t.push, t.back, t.confirm, t.sample});
		do @(posedge clk); while (!s_tready);
		pending_readouts.push_back(next_scale_readout(t));
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic write_start_divisor(input logic [START_BITS-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		div_val = longint'(value);
	endtask

	task automatic test_scale_mode();
		send_tick(tick_of(1'b1, 24'sh7FFFFF, 1'b0, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh800000, 1'b0, 1'b0, 1'b0, 16'd0));
		// no sample: net and weight hold
		send_tick(tick_of(1'b0, 24'sh5A5A5A, 1'b0, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh800000, 1'b1, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh7FFFFF, 1'b1, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh000000, 1'b0, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh7FFFFF, 1'b1, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b1, 24'sh800000, 1'b0, 1'b0, 1'b0, 16'd0));
	endtask

	task automatic test_calibrate_mode();
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b1, 16'd0));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd2));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd1));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'h7FFF));
		// wrap across the count boundary, then the largest negative step
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'h8000));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'h0000));
		send_tick(tick_of(1'b1, 24'sd12345, 1'b1, 1'b0, 1'b0, 16'd0));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b1, 16'd6));
		// save and cancel in one tick
		send_tick(tick_of(1'b0, 24'sh0, 1'b1, 1'b1, 1'b0, 16'd12));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd12));
		// tare and enter calibrate in one tick
		send_tick(tick_of(1'b1, -24'sd5, 1'b1, 1'b0, 1'b1, 16'd12));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b1, 1'b0, 16'd12));
	endtask

	task automatic test_start_divisor_extremes();
		write_start_divisor(START_BITS'(1));
		send_tick(tick_of(1'b1, 24'sh7FFFFF, 1'b0, 1'b0, 1'b0, 16'd12));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b1, 16'd12));
		// one below one lands on zero and is forced back to one
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd10));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd4));
		send_tick(tick_of(1'b1, 24'sh800000, 1'b0, 1'b0, 1'b0, 16'd4));
		send_tick(tick_of(1'b1, 24'sd100, 1'b0, 1'b1, 1'b0, 16'd4));
		write_start_divisor(DIVISOR_MAX[START_BITS-1:0]);
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b1, 16'd4));
		send_tick(tick_of(1'b0, 24'sh0, 1'b0, 1'b0, 1'b0, 16'd44));
		send_tick(tick_of(1'b1, 24'sh7FFFFF, 1'b1, 1'b0, 1'b0, 16'd44));
		write_start_divisor('0);
		send_tick(tick_of(1'b1, 24'sd77, 1'b0, 1'b0, 1'b0, 16'd44));
	endtask

	task automatic run_random_phase(input logic [START_BITS-1:0] start_div,
			input rx_style_t style, input bit gaps, input int count);
		write_start_divisor(start_div);
		rx_style = style;
		sender_gaps = gaps;
		enc_lvl = enc_prev;
		btn_lvl = btn_prev;
		repeat (count) send_tick(random_tick());
	endtask

	task automatic test_random_traffic();
		run_random_phase(DEFAULT_DIVISOR[START_BITS-1:0], RX_ALWAYS, 1'b0, 150);
		run_random_phase(START_BITS'($urandom_range(1, 5000)), RX_RANDOM, 1'b1, 200);
		run_random_phase(START_BITS'($urandom()), RX_PATTERN, 1'b1, 200);
		run_random_phase(START_BITS'($urandom_range(1, 100)), RX_RANDOM, 1'b1, 200);
	endtask

	task automatic test_output_hold_off();
		rx_style = RX_RANDOM;
		sender_gaps = 1'b0;
		hold_req = 1'b1;
		repeat (12) send_tick(random_tick());
		sender_gaps = 1'b1;
		repeat (20) send_tick(random_tick());
	endtask

	initial begin : receiver
		logic [10:0] rx_pattern;
		int          rx_phase;
		rx_pattern = 11'b101_1001_1101;
		rx_phase = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (rx_style)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default:   m_tready <= rx_pattern[rx_phase];
			endcase
			rx_phase = (rx_phase + 1) % 11;
		end
	end

	always @(posedge clk) begin : readout_check
		readout_t got;
		readout_t want;
		if (m_tvalid && m_tready) begin
			got = unpack_readout(m_tdata);
			if (pending_readouts.size() == 0) begin
				$error("readout with no tick outstanding");
				mismatches++;
			end else begin
				want = pending_readouts.pop_front();
				check_field("weight_tenths", want.weight, got.weight);
				check_field("net_code", want.net, got.net);
				check_field("held_sample", want.held, got.held);
				check_field("tared", want.tared, got.tared);
				check_field("mode", want.mode, got.mode);
				check_field("divisor", want.divisor, got.divisor);
				check_field("save_now", want.save_now, got.save_now);
				check_field("save_value", want.save_value, got.save_value);
				check_field("notice", want.notice, got.notice);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("scale_tare_calibrate_controller_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scale_mode();
		test_calibrate_mode();
		test_start_divisor_extremes();
		test_random_traffic();
		test_output_hold_off();
		s_tvalid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("scale_tare_calibrate_controller_top regression: pass");
		else
			$display("scale_tare_calibrate_controller_top regression: fail");
		$finish;
	end

endmodule
